// ----- design/ftsm_pkg.sv -----
// types, codes and helpers shared by the frame time and memory statistics monitor
package ftsm_pkg;

   localparam logic [2:0] OP_SETUP  = 3'd0;
   localparam logic [2:0] OP_BEGIN  = 3'd1;
   localparam logic [2:0] OP_END    = 3'd2;
   localparam logic [2:0] OP_SWITCH = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   localparam logic [2:0] CMD_SETUP  = 3'd0;
   localparam logic [2:0] CMD_BEGIN  = 3'd1;
   localparam logic [2:0] CMD_END    = 3'd2;
   localparam logic [2:0] CMD_SWITCH = 3'd3;
   localparam logic [2:0] CMD_CLEAR  = 3'd4;
   localparam logic [2:0] CMD_NONE   = 3'd7;

   localparam logic [31:0] FPS_SCALE = 32'd10000000;
   localparam logic [15:0] MODE_UNSET = 16'hFFFF;

   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = 5;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [15:0] mode_id;
      logic [31:0]        free_memory;
      logic [31:0]        time_us;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] current_mode;
      logic [31:0]        frames_counted;
      logic [31:0]        last_frame_us;
      logic [31:0]        average_frame_us;
      logic [31:0]        worst_frame_us;
      logic [31:0]        lowest_free_overall;
      logic [31:0]        lowest_free_in_mode;
      logic [31:0]        free_before_frame;
      logic [31:0]        free_after_frame;
      logic [31:0]        startup_free;
      logic [31:0]        mode_switches;
      logic [23:0]        fps_tenths;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] mode;
      logic [31:0] sample;
      logic [31:0] now;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } q_push_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

   // zero minimum means unset
   function automatic logic [31:0] min_track(logic [31:0] cur, logic [31:0] sample);
      return ((cur == 32'd0) || (sample < cur)) ? sample : cur;
   endfunction

endpackage

// ----- design/ftsm_front.sv -----
// front end: takes request words and classifies them into queue commands
module ftsm_front (
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ftsm_pkg::req_word_type req_word,
   input  logic                  q_full,
   output ftsm_pkg::q_push_type  q_push
);
   import ftsm_pkg::*;

   logic [2:0] kind;

   always_comb begin
      case (req_word.opcode)
         OP_SETUP:  kind = CMD_SETUP;
         OP_BEGIN:  kind = CMD_BEGIN;
         OP_END:    kind = CMD_END;
         OP_SWITCH: kind = CMD_SWITCH;
         OP_CLEAR:  kind = CMD_CLEAR;
         default:   kind = CMD_NONE;
      endcase
   end

   assign req_stall         = q_full;
   assign q_push.push       = req_valid && !q_full;
   assign q_push.cmd.kind   = kind;
   assign q_push.cmd.mode   = req_word.mode_id;
   assign q_push.cmd.sample = req_word.free_memory;
   assign q_push.cmd.now    = req_word.time_us;

endmodule

// ----- design/ftsm_queue.sv -----
// short command queue between front end and back end
module ftsm_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ftsm_pkg::q_push_type q_push,
   output logic                 q_full,
   output ftsm_pkg::q_head_type q_head,
   input  logic                 q_pop
);
   import ftsm_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          slots_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_full       = (count_ff == CNT_W'(DEPTH));
   assign q_head.valid = (count_ff != '0);
   assign q_head.cmd   = slots_ff[rd_ptr_ff];
   assign do_push      = q_push.push && !q_full;
   assign do_pop       = q_pop && q_head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= q_push.cmd;
      end
   end

endmodule

// ----- design/ftsm_div.sv -----
// shared restoring divider, one quotient bit per cycle
module ftsm_div (
   input  logic                  clock,
   input  logic                  reset,
   input  ftsm_pkg::div_req_type div_req,
   output ftsm_pkg::div_rsp_type div_rsp
);
   import ftsm_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]          quo_ff, quo_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          divisor_ff, divisor_in;
   logic [32:0]          shifted;
   logic [32:0]          trial;

   assign shifted = {rem_ff, quo_ff[31]};
   assign trial   = shifted - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         quo_in     = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- design/ftsm_back.sv -----
// back end: statistics registers, average and fps updates, result register
module ftsm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ftsm_pkg::q_head_type   q_head,
   output logic                   q_pop,
   output ftsm_pkg::div_req_type  div_req,
   input  ftsm_pkg::div_rsp_type  div_rsp,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ftsm_pkg::rsp_word_type rsp_word
);
   import ftsm_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_DIV_AVG = 2'd1;
   localparam logic [1:0] ST_DIV_FPS = 2'd2;
   localparam logic [1:0] ST_PUB     = 2'd3;

   logic [1:0]   state_ff, state_in;
   logic [15:0]  mode_ff, mode_in;
   logic [31:0]  startup_ff, startup_in;
   logic [31:0]  min_ff, min_in;
   logic [31:0]  mode_min_ff, mode_min_in;
   logic [31:0]  before_ff, before_in;
   logic [31:0]  after_ff, after_in;
   logic [31:0]  start_ff, start_in;
   logic [31:0]  last_ff, last_in;
   logic [31:0]  avg_ff, avg_in;
   logic [31:0]  worst_ff, worst_in;
   logic [31:0]  count_ff, count_in;
   logic [31:0]  switch_ff, switch_in;
   logic [23:0]  fps_ff, fps_in;
   logic         sub_ff, sub_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;
   cmd_type      cmd;
   logic [31:0]  dur;
   logic [31:0]  avg_new;
   logic         reset_mode;

   assign cmd     = q_head.cmd;
   assign dur     = cmd.now - start_ff;
   assign avg_new = sub_ff ? (avg_ff - div_rsp.quotient) : (avg_ff + div_rsp.quotient);
   assign q_pop   = (state_ff == ST_IDLE) && q_head.valid;

   always_comb begin
      reset_mode = 1'b0;
      case (cmd.kind)
         CMD_SETUP:  reset_mode = 1'b1;
         CMD_BEGIN:  reset_mode = (mode_ff != cmd.mode);
         CMD_SWITCH: reset_mode = 1'b1;
         CMD_CLEAR:  reset_mode = 1'b1;
         default:    reset_mode = 1'b0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      startup_in   = startup_ff;
      min_in       = min_ff;
      mode_min_in  = mode_min_ff;
      before_in    = before_ff;
      after_in     = after_ff;
      start_in     = start_ff;
      last_in      = last_ff;
      avg_in       = avg_ff;
      worst_in     = worst_ff;
      count_in     = count_ff;
      switch_in    = switch_ff;
      fps_in       = fps_ff;
      sub_in       = sub_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      div_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               state_in = ST_PUB;
               if (cmd.kind == CMD_SETUP) begin
                  startup_in = cmd.sample;
                  min_in     = cmd.sample;
               end
               if (cmd.kind == CMD_CLEAR) begin
                  min_in = cmd.sample;
               end
               if ((cmd.kind == CMD_SWITCH) || (cmd.kind == CMD_BEGIN && reset_mode)) begin
                  switch_in = switch_ff + 32'd1;
               end
               if (reset_mode) begin
                  mode_in     = cmd.mode;
                  before_in   = '0;
                  after_in    = '0;
                  mode_min_in = cmd.sample;
                  last_in     = '0;
                  avg_in      = '0;
                  worst_in    = '0;
                  count_in    = '0;
                  fps_in      = '0;
                  min_in      = min_track(min_in, cmd.sample);
               end
               if (cmd.kind == CMD_BEGIN) begin
                  before_in   = cmd.sample;
                  min_in      = min_track(min_in, cmd.sample);
                  mode_min_in = min_track(mode_min_in, cmd.sample);
                  start_in    = cmd.now;
               end
               if (cmd.kind == CMD_END) begin
                  after_in    = cmd.sample;
                  min_in      = min_track(min_ff, cmd.sample);
                  mode_min_in = min_track(mode_min_ff, cmd.sample);
                  last_in     = dur;
                  fps_in      = '0;
                  if (dur > worst_ff) begin
                     worst_in = dur;
                  end
                  count_in = (count_ff == 32'hFFFF_FFFF) ? count_ff : count_ff + 32'd1;
                  if (count_in == 32'd1) begin
                     avg_in = dur;
                     if (dur != 32'd0) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = FPS_SCALE;
                        div_req.divisor  = dur;
                        state_in         = ST_DIV_FPS;
                     end
                  end else begin
                     sub_in           = (dur < avg_ff);
                     div_req.start    = 1'b1;
                     div_req.dividend = (dur < avg_ff) ? (avg_ff - dur) : (dur - avg_ff);
                     div_req.divisor  = count_in;
                     state_in         = ST_DIV_AVG;
                  end
               end
            end
         end
         ST_DIV_AVG: begin
            if (div_rsp.done) begin
               avg_in = avg_new;
               if (avg_new != 32'd0) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = FPS_SCALE;
                  div_req.divisor  = avg_new;
                  state_in         = ST_DIV_FPS;
               end else begin
                  state_in = ST_PUB;
               end
            end
         end
         ST_DIV_FPS: begin
            if (div_rsp.done) begin
               fps_in   = div_rsp.quotient[23:0];
               state_in = ST_PUB;
            end
         end
         ST_PUB: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                     = 1'b1;
               rsp_word_in.current_mode         = mode_ff;
               rsp_word_in.frames_counted       = count_ff;
               rsp_word_in.last_frame_us        = last_ff;
               rsp_word_in.average_frame_us     = avg_ff;
               rsp_word_in.worst_frame_us       = worst_ff;
               rsp_word_in.lowest_free_overall  = min_ff;
               rsp_word_in.lowest_free_in_mode  = mode_min_ff;
               rsp_word_in.free_before_frame    = before_ff;
               rsp_word_in.free_after_frame     = after_ff;
               rsp_word_in.startup_free         = startup_ff;
               rsp_word_in.mode_switches        = switch_ff;
               rsp_word_in.fps_tenths           = fps_ff;
               state_in                         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_UNSET;
         startup_ff   <= '0;
         min_ff       <= '0;
         mode_min_ff  <= '0;
         before_ff    <= '0;
         after_ff     <= '0;
         start_ff     <= '0;
         last_ff      <= '0;
         avg_ff       <= '0;
         worst_ff     <= '0;
         count_ff     <= '0;
         switch_ff    <= '0;
         fps_ff       <= '0;
         sub_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         startup_ff   <= startup_in;
         min_ff       <= min_in;
         mode_min_ff  <= mode_min_in;
         before_ff    <= before_in;
         after_ff     <= after_in;
         start_ff     <= start_in;
         last_ff      <= last_in;
         avg_ff       <= avg_in;
         worst_ff     <= worst_in;
         count_ff     <= count_in;
         switch_ff    <= switch_in;
         fps_ff       <= fps_in;
         sub_ff       <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_pub_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUB) |-> !div_rsp.busy)
      else $error("divider busy while publishing");

   a_fps_needs_avg: assert property (@(posedge clock) disable iff (reset)
      (fps_ff != 24'd0) |-> (avg_ff != 32'd0))
      else $error("fps set with zero average");

   a_last_le_worst: assert property (@(posedge clock) disable iff (reset)
      (last_ff <= worst_ff))
      else $error("last frame exceeds worst frame");

   a_pop_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff != ST_IDLE))
      else $error("back end stayed idle after pop");

endmodule

// ----- design/frame_time_memory_stats_monitor.sv -----
// top level of the frame time and free memory statistics monitor
// Every request word (setup, begin frame, end frame, mode change, stats reset or an unknown
// opcode) returns one snapshot word. Setup, begin, mode change, stats reset and unknown opcodes
// pass through the back end without the divider. An end-frame word takes two 32-step passes
// through the shared restoring divider (average step by frame count, then 10000000 by the
// average), or one pass when one is enough (first frame of a mode, or an average that lands
// on zero), and none when the first frame of a mode has zero length. A word accepted with the
// queue empty and the back end idle is taken by the back end on the next edge, and a short
// word's snapshot then goes from the back end's publish state into the result register.
// Requests are queued QUEUE_DEPTH deep ahead of the back end, and a finished snapshot sits
// in the result register while the back end works on the next word; a stalled result holds
// the back end once its next snapshot is ready.
module frame_time_memory_stats_monitor #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ftsm_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ftsm_pkg::rsp_word_type rsp_word
);
   import ftsm_pkg::*;

   q_push_type  q_push;
   q_head_type  q_head;
   logic        q_full;
   logic        q_pop;
   div_req_type div_req;
   div_rsp_type div_rsp;

   ftsm_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .q_full    (q_full),
      .q_push    (q_push)
   );

   ftsm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_full (q_full),
      .q_head (q_head),
      .q_pop  (q_pop)
   );

   ftsm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   ftsm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- tb/tb_frame_time_memory_stats_monitor.sv -----
// self-checking testbench for the frame time and free memory statistics monitor
module tb_frame_time_memory_stats_monitor;
   timeunit 1ns;
   timeprecision 1ps;

   import ftsm_pkg::*;

   localparam logic [2:0] OP_RSVD_5 = 3'd5;
   localparam logic [2:0] OP_RSVD_6 = 3'd6;
   localparam logic [2:0] OP_RSVD_7 = 3'd7;
   localparam int RANDOM_WORDS = 2000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      req_word_type word;
      logic         pinned;
      rsp_word_type want;
   } script_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   // shadow of the statistics registers
   logic [15:0] mode_now;
   logic [31:0] startup_level;
   logic [31:0] low_all;
   logic [31:0] low_mode;
   logic [31:0] free_before;
   logic [31:0] free_after;
   logic [31:0] frame_t0;
   logic [31:0] dur_last;
   logic [31:0] dur_avg;
   logic [31:0] dur_worst;
   logic [31:0] frame_total;
   logic [31:0] switch_total;

   rsp_word_type   snapshot_q[$];
   script_row_type opening_rows[$];
   logic [2:0]     spare_ops[3] = '{OP_RSVD_5, OP_RSVD_6, OP_RSVD_7};

   int idle_pct = 19;
   int hold_asked = 0;
   int hold_taken = 0;
   int hold_left = 0;
   int words_sent = 0;
   int frame_ends = 0;
   int snapshots_seen = 0;
   int mismatches = 0;

   logic        in_frame = 1'b0;
   logic [31:0] now_us = 32'd0;
   logic [31:0] free_level = 32'h0400_0000;

   frame_time_memory_stats_monitor uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic req_word_type mk_req(logic [2:0] op, logic [15:0] mode,
                                           logic [31:0] free, logic [31:0] t);
      req_word_type w;
      w.opcode = op;
      w.mode_id = mode;
      w.free_memory = free;
      w.time_us = t;
      return w;
   endfunction

   task automatic add_row(input req_word_type w, input logic pinned, input rsp_word_type want);
      script_row_type row;
      row.word = w;
      row.pinned = pinned;
      row.want = want;
      opening_rows.push_back(row);
   endtask

   // zero minimum means unset
   task automatic take_sample(input logic [31:0] s);
      if (low_all == 32'd0 || s < low_all) low_all = s;
      if (low_mode == 32'd0 || s < low_mode) low_mode = s;
   endtask

   task automatic restart_mode(input logic [15:0] m, input logic [31:0] s);
      mode_now = m;
      free_before = 32'd0;
      free_after = 32'd0;
      low_mode = s;
      dur_last = 32'd0;
      dur_avg = 32'd0;
      dur_worst = 32'd0;
      frame_total = 32'd0;
      take_sample(s);
   endtask

   task automatic predict_snapshot(input req_word_type w, output rsp_word_type s);
      logic [31:0] dur;
      case (w.opcode)
         OP_SETUP: begin
            startup_level = w.free_memory;
            low_all = w.free_memory;
            restart_mode(w.mode_id, w.free_memory);
         end
         OP_BEGIN: begin
            if (mode_now != w.mode_id) begin
               switch_total = switch_total + 32'd1;
               restart_mode(w.mode_id, w.free_memory);
            end
            free_before = w.free_memory;
            take_sample(w.free_memory);
            frame_t0 = w.time_us;
         end
         OP_END: begin
            dur = w.time_us - frame_t0;
            free_after = w.free_memory;
            take_sample(w.free_memory);
            dur_last = dur;
            if (frame_total != 32'hFFFF_FFFF) frame_total = frame_total + 32'd1;
            if (frame_total == 32'd1) begin
               dur_avg = dur;
            end else if (dur >= dur_avg) begin
               dur_avg = dur_avg + (dur - dur_avg) / frame_total;
            end else begin
               dur_avg = dur_avg - (dur_avg - dur) / frame_total;
            end
            if (dur > dur_worst) dur_worst = dur;
         end
         OP_SWITCH: begin
            switch_total = switch_total + 32'd1;
            restart_mode(w.mode_id, w.free_memory);
         end
         OP_CLEAR: begin
            low_all = w.free_memory;
            restart_mode(w.mode_id, w.free_memory);
         end
         default: begin
         end
      endcase
      s.current_mode = mode_now;
      s.frames_counted = frame_total;
      s.last_frame_us = dur_last;
      s.average_frame_us = dur_avg;
      s.worst_frame_us = dur_worst;
      s.lowest_free_overall = low_all;
      s.lowest_free_in_mode = low_mode;
      s.free_before_frame = free_before;
      s.free_after_frame = free_after;
      s.startup_free = startup_level;
      s.mode_switches = switch_total;
      s.fps_tenths = (dur_avg != 32'd0) ? 24'(FPS_SCALE / dur_avg) : 24'd0;
   endtask

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      mismatches++;
      $display("mismatch at snapshot %0d: %s got %h expected %h", snapshots_seen, what, got,
               want);
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) note_mismatch(what, got, want);
   endtask

   task automatic check_snapshot(input rsp_word_type got);
      rsp_word_type want;
      snapshots_seen++;
      if (snapshot_q.size() == 0) begin
         note_mismatch("word with nothing expected, mode", {16'd0, got.current_mode}, 32'd0);
      end else begin
         want = snapshot_q.pop_front();
         check_field("current_mode", {16'd0, got.current_mode}, {16'd0, want.current_mode});
         check_field("frames_counted", got.frames_counted, want.frames_counted);
         check_field("last_frame_us", got.last_frame_us, want.last_frame_us);
         check_field("average_frame_us", got.average_frame_us, want.average_frame_us);
         check_field("worst_frame_us", got.worst_frame_us, want.worst_frame_us);
         check_field("lowest_free_overall", got.lowest_free_overall,
                     want.lowest_free_overall);
         check_field("lowest_free_in_mode", got.lowest_free_in_mode,
                     want.lowest_free_in_mode);
         check_field("free_before_frame", got.free_before_frame, want.free_before_frame);
         check_field("free_after_frame", got.free_after_frame, want.free_after_frame);
         check_field("startup_free", got.startup_free, want.startup_free);
         check_field("mode_switches", got.mode_switches, want.mode_switches);
         check_field("fps_tenths", {8'd0, got.fps_tenths}, {8'd0, want.fps_tenths});
      end
   endtask

   task automatic offer_word(input req_word_type w, input logic pinned,
                             input rsp_word_type want);
      rsp_word_type s;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_snapshot(w, s);
      snapshot_q.push_back(pinned ? want : s);
      words_sent++;
      if (w.opcode == OP_END) frame_ends++;
   endtask

   function automatic logic [15:0] pick_mode();
      int r;
      r = $urandom_range(99);
      if (r < 40) return mode_now;
      if (r < 80) return 16'($urandom_range(3));
      return 16'($urandom);
   endfunction

   function automatic logic [31:0] pick_free();
      int r;
      r = $urandom_range(99);
      if (r < 3) return 32'd0;
      if (r < 6) return 32'hFFFF_FFFF;
      if (r < 14) return $urandom;
      return free_level - 32'($urandom_range(1 << 20));
   endfunction

   // mostly begin/end pairs in a steady mode, with mode events and noise mixed in
   task automatic next_random_word(output req_word_type w);
      int r;
      logic [31:0] len;
      r = $urandom_range(99);
      now_us = now_us + 32'($urandom_range(1, 400));
      if ($urandom_range(99) < 2) free_level = $urandom;
      w = mk_req(OP_BEGIN, pick_mode(), pick_free(), now_us);
      if (r < 4) begin
         w.opcode = spare_ops[$urandom_range(2)];
         w.time_us = $urandom;
      end else if (r < 7) begin
         w.opcode = OP_SETUP;
         in_frame = 1'b0;
      end else if (r < 10) begin
         w.opcode = OP_SWITCH;
         in_frame = 1'b0;
      end else if (r < 13) begin
         w.opcode = OP_CLEAR;
         in_frame = 1'b0;
      end else if (r < 17) begin
         w.opcode = ($urandom_range(1) != 0) ? OP_END : OP_BEGIN;
         w.mode_id = 16'($urandom);
         w.time_us = $urandom;
         in_frame = 1'($urandom_range(1));
      end else if (!in_frame) begin
         if ($urandom_range(99) < 85) w.mode_id = mode_now;
         in_frame = 1'b1;
      end else begin
         r = $urandom_range(99);
         if (r < 5) begin
            len = 32'($urandom_range(50));
         end else if (r < 8) begin
            len = $urandom;
         end else begin
            len = 32'($urandom_range(8000, 40000));
         end
         now_us = now_us + len;
         w.opcode = OP_END;
         w.time_us = now_us;
         in_frame = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_snapshot(rsp_word);
      if (hold_asked != hold_taken) begin
         hold_taken = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   initial begin
      req_word_type w;
      mode_now = 16'hFFFF;
      startup_level = 32'd0;
      low_all = 32'd0;
      low_mode = 32'd0;
      free_before = 32'd0;
      free_after = 32'd0;
      frame_t0 = 32'd0;
      dur_last = 32'd0;
      dur_avg = 32'd0;
      dur_worst = 32'd0;
      frame_total = 32'd0;
      switch_total = 32'd0;

      add_row(mk_req(OP_RSVD_5, 16'h1234, 32'hDEAD_BEEF, 32'd1), 1'b1,
              rsp_word_type'{16'hFFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                             32'd0, 32'd0, 32'd0, 24'd0});
      // end of frame with no begin since reset
      add_row(mk_req(OP_END, 16'h0000, 32'd500, 32'd1000), 1'b1,
              rsp_word_type'{16'hFFFF, 32'd1, 32'd1000, 32'd1000, 32'd1000, 32'd500, 32'd500,
                             32'd0, 32'd500, 32'd0, 32'd0, 24'd10000});
      add_row(mk_req(OP_SETUP, 16'h0000, 32'hFFFF_FFFF, 32'd0), 1'b1,
              rsp_word_type'{16'h0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 24'd0});
      add_row(mk_req(OP_BEGIN, 16'h0000, 32'd100, 32'hFFFF_FFF0), 1'b0, '0);
      add_row(mk_req(OP_END, 16'hFFFF, 32'd0, 32'h0000_0010), 1'b0, '0);
      add_row(mk_req(OP_BEGIN, 16'h8000, 32'd1, 32'd5), 1'b0, '0);
      add_row(mk_req(OP_END, 16'h8000, 32'd7, 32'd5), 1'b0, '0);
      add_row(mk_req(OP_BEGIN, 16'h8000, 32'd2000, 32'd0), 1'b0, '0);
      add_row(mk_req(OP_END, 16'h8000, 32'h8000_0000, 32'hFFFF_FFFF), 1'b0, '0);
      add_row(mk_req(OP_BEGIN, 16'h7FFF, 32'd3000, 32'd100), 1'b0, '0);
      add_row(mk_req(OP_END, 16'h7FFF, 32'd4000, 32'd101), 1'b0, '0);
      add_row(mk_req(OP_BEGIN, 16'h7FFF, 32'd3500, 32'd200), 1'b0, '0);
      add_row(mk_req(OP_END, 16'h7FFF, 32'd3600, 32'd150), 1'b0, '0);
      add_row(mk_req(OP_BEGIN, 16'h7FFF, 32'd3700, 32'd300), 1'b0, '0);
      add_row(mk_req(OP_END, 16'h7FFF, 32'd3800, 32'd310), 1'b0, '0);
      add_row(mk_req(OP_SWITCH, 16'h7FFF, 32'd50, 32'd400), 1'b0, '0);
      add_row(mk_req(OP_CLEAR, 16'h0005, 32'd1, 32'd500), 1'b0, '0);
      add_row(mk_req(OP_RSVD_6, 16'h5A5A, 32'h1234_5678, 32'h8765_4321), 1'b0, '0);
      add_row(mk_req(OP_RSVD_7, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, '0);
      add_row(mk_req(OP_END, 16'h0005, 32'hFFFF_FFFF, 32'd0), 1'b0, '0);
      add_row(mk_req(OP_SETUP, 16'hFFFF, 32'd0, 32'd0), 1'b0, '0);
      add_row(mk_req(OP_BEGIN, 16'hFFFF, 32'd123, 32'd42), 1'b0, '0);
      add_row(mk_req(OP_END, 16'hFFFF, 32'h5555_5555, 32'hAAAA_AAAA), 1'b0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_rows[i])
         offer_word(opening_rows[i].word, opening_rows[i].pinned, opening_rows[i].want);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 600) hold_asked++;
         if (n == 1200) begin
            req_valid <= 1'b0;
            while (snapshot_q.size() != 0) @(posedge clock);
         end
         if (n == 1300) idle_pct = 0;
         if (n == 1600) idle_pct = 19;
         next_random_word(w);
         offer_word(w, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (snapshot_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);

      $display("%0d event words sent, %0d of them frame ends, %0d snapshots checked",
               words_sent, frame_ends, snapshots_seen);
      $display("%0d mismatches over setup, frame, mode change, stats reset and spare opcodes",
               mismatches);
      if (mismatches == 0) begin
         $display("tb_frame_time_memory_stats_monitor passed");
      end else begin
         $display("tb_frame_time_memory_stats_monitor failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d snapshots outstanding", snapshot_q.size());
      $display("tb_frame_time_memory_stats_monitor failed");
      $finish;
   end

endmodule
